>>> rtl/sefr_pkg.sv
// Shared constants and types for the STX/ETX escaped frame receiver.
// No dependencies; every other file in rtl/ but sefr_ram refers to this package by scoped names.
`default_nettype none

package sefr_pkg;

    // message store geometry
    localparam int MSG_MAX = 32;
    localparam int IDX_W   = $clog2(MSG_MAX);
    localparam int LEN_W   = $clog2(MSG_MAX + 1);
    localparam int BANKS   = 2;
    localparam int RAM_DEPTH = BANKS * MSG_MAX;
    localparam int RAM_AW  = $clog2(RAM_DEPTH);

    // payload widths
    localparam int BYTE_W   = 8;
    localparam int OIDX_W   = 5;
    localparam int OLEN_W   = 6;

    // framing bytes
    localparam logic [BYTE_W-1:0] BYTE_START = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_ESC   = 8'h10;

    // message kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_CODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_CODE = 1'b1;

    // one finished message waiting to be drained
    typedef struct packed {
        logic             bank;
        logic             kind;
        logic [LEN_W-1:0] len;
    } desc_t;

    // drain-complete notice from back end to front end
    typedef struct packed {
        logic valid;
        logic bank;
    } done_t;

endpackage

`default_nettype wire

>>> rtl/sefr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sefr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sefr_front.sv
// Front end: frame hunting, escape decoding, store writes, type check at frame end.
// Depends on sefr_pkg; writes into the banked message RAM.
`default_nettype none

module sefr_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    input  wire logic [sefr_pkg::BYTE_W-1:0]      rx_byte,
    output logic                                  full,
    input  wire logic [sefr_pkg::BYTE_W-1:0]      request_code,
    input  wire logic [sefr_pkg::BYTE_W-1:0]      command_code,
    output logic                                  ram_we,
    output logic      [sefr_pkg::RAM_AW-1:0]      ram_addr,
    output logic      [sefr_pkg::BYTE_W-1:0]      ram_data,
    output logic                                  desc_push,
    output sefr_pkg::desc_t                       desc,
    input  wire sefr_pkg::done_t                  done
);

    typedef enum logic [2:0] {
        MODE_HUNT  = 3'b001,
        MODE_STORE = 3'b010,
        MODE_FULL  = 3'b100
    } mode_t;

    mode_t                          mode_reg, mode_next;
    logic                           esc_reg, esc_next;
    logic [sefr_pkg::LEN_W-1:0]     fill_reg, fill_next;
    logic                           bank_reg, bank_next;
    logic [1:0]                     busy_reg, busy_next;
    logic [sefr_pkg::BYTE_W-1:0]    type_reg, type_next;

    logic                           accept;
    logic                           store_en;
    logic [sefr_pkg::BYTE_W-1:0]    store_val;
    logic [sefr_pkg::LEN_W-1:0]     fill_inc;

    // the bank being filled must not still be draining
    assign full   = busy_reg[bank_reg];
    assign accept = push && !full;
    assign fill_inc = fill_reg + sefr_pkg::LEN_W'(1);

    assign ram_we   = store_en;
    assign ram_addr = {bank_reg, fill_reg[sefr_pkg::IDX_W-1:0]};
    assign ram_data = store_val;

    always_comb
    begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        fill_next = fill_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        type_next = type_reg;
        store_en  = 1'b0;
        store_val = rx_byte;
        desc_push = 1'b0;
        desc.bank = bank_reg;
        desc.kind = sefr_pkg::KIND_REQUEST;
        desc.len  = fill_reg;

        if (done.valid)
        begin
            busy_next[done.bank] = 1'b0;
        end

        if (accept)
        begin
            unique case (mode_reg)
                MODE_HUNT:
                begin
                    if (rx_byte == sefr_pkg::BYTE_START)
                    begin
                        mode_next = MODE_STORE;
                        esc_next  = 1'b0;
                        fill_next = '0;
                    end
                end
                MODE_STORE, MODE_FULL:
                begin
                    if (rx_byte == sefr_pkg::BYTE_END)
                    begin
                        // end byte wins even over a pending escape
                        mode_next = MODE_HUNT;
                        esc_next  = 1'b0;
                        fill_next = '0;
                        if (fill_reg >= sefr_pkg::LEN_W'(2))
                        begin
                            if (type_reg == request_code)
                            begin
                                desc_push = 1'b1;
                                desc.kind = sefr_pkg::KIND_REQUEST;
                            end
                            else if (type_reg == command_code)
                            begin
                                desc_push = 1'b1;
                                desc.kind = sefr_pkg::KIND_COMMAND;
                            end
                        end
                        if (desc_push)
                        begin
                            busy_next[bank_reg] = 1'b1;
                            bank_next = !bank_reg;
                        end
                    end
                    else if (mode_reg == MODE_STORE)
                    begin
                        if (esc_reg)
                        begin
                            esc_next  = 1'b0;
                            store_en  = 1'b1;
                            store_val = rx_byte - sefr_pkg::BYTE_ESC;
                        end
                        else if (rx_byte == sefr_pkg::BYTE_ESC)
                        begin
                            esc_next = 1'b1;
                        end
                        else
                        begin
                            store_en = 1'b1;
                        end
                    end
                end
                default:
                begin
                    mode_next = MODE_HUNT;
                end
            endcase
        end

        if (store_en)
        begin
            fill_next = fill_inc;
            if (fill_reg == sefr_pkg::LEN_W'(1))
            begin
                type_next = store_val;
            end
            if (fill_inc == sefr_pkg::LEN_W'(sefr_pkg::MSG_MAX))
            begin
                mode_next = MODE_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HUNT;
            esc_reg  <= 1'b0;
            fill_reg <= '0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
            fill_reg <= fill_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
    end

endmodule

`default_nettype wire

>>> rtl/sefr_desc_queue.sv
// Two-entry queue of finished-message descriptors between front and back ends.
// Depends on sefr_pkg.
`default_nettype none

module sefr_desc_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sefr_pkg::desc_t push_desc,
    input  wire logic            pop,
    output logic                 valid,
    output sefr_pkg::desc_t      head
);

    sefr_pkg::desc_t  entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign valid = (count_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop && valid)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop && valid})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sefr_back.sv
// Back end: drains one stored message per descriptor into the result register.
// Depends on sefr_pkg; reads the banked message RAM.
`default_nettype none

module sefr_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           desc_valid,
    input  wire sefr_pkg::desc_t                desc,
    output logic                                desc_pop,
    output sefr_pkg::done_t                     done,
    output logic                                ram_re,
    output logic      [sefr_pkg::RAM_AW-1:0]    ram_addr,
    input  wire logic [sefr_pkg::BYTE_W-1:0]    ram_data,
    output logic                                empty,
    input  wire logic                           pop,
    output logic      [sefr_pkg::BYTE_W-1:0]    out_byte,
    output logic                                msg_kind,
    output logic      [sefr_pkg::OIDX_W-1:0]    byte_index,
    output logic      [sefr_pkg::OLEN_W-1:0]    msg_length,
    output logic                                last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_LOAD  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [sefr_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic                           oval_reg, oval_next;
    logic [sefr_pkg::BYTE_W-1:0]    obyte_reg;
    logic                           okind_reg;
    logic [sefr_pkg::OIDX_W-1:0]    oidx_reg;
    logic [sefr_pkg::OLEN_W-1:0]    olen_reg;
    logic                           olast_reg;
    logic                           is_last;
    logic                           load;

    assign is_last  = (sefr_pkg::LEN_W'(idx_reg) + sefr_pkg::LEN_W'(1)) == desc.len;
    assign ram_addr = {desc.bank, idx_reg};

    assign empty      = !oval_reg;
    assign out_byte   = obyte_reg;
    assign msg_kind   = okind_reg;
    assign byte_index = oidx_reg;
    assign msg_length = olen_reg;
    assign last       = olast_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        oval_next  = oval_reg;
        ram_re     = 1'b0;
        load       = 1'b0;
        desc_pop   = 1'b0;
        done.valid = 1'b0;
        done.bank  = desc.bank;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (desc_valid)
                begin
                    idx_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                ram_re     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                load       = 1'b1;
                oval_next  = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (pop)
                begin
                    oval_next = 1'b0;
                    if (olast_reg)
                    begin
                        desc_pop   = 1'b1;
                        done.valid = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + sefr_pkg::IDX_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            obyte_reg <= ram_data;
            okind_reg <= desc.kind;
            oidx_reg  <= sefr_pkg::OIDX_W'(idx_reg);
            olen_reg  <= sefr_pkg::OLEN_W'(desc.len);
            olast_reg <= is_last;
        end
    end

endmodule

`default_nettype wire

>>> rtl/stx_etx_escaped_frame_receiver.sv
// STX/ETX escaped frame receiver, top level. After the end byte of an accepted message
// is accepted, its descriptor passes through the queue, then the back end reads the first
// byte from the RAM and loads it; each further byte is read and loaded only after the
// previous one is popped. Input takes one byte per cycle while full is low; full rises
// only when both store banks still hold messages waiting to drain. Reset (rst_n, async
// low): hunting, store empty, request_code 0, command_code 1. Depends on sefr_pkg,
// sefr_ram, sefr_front, sefr_desc_queue, sefr_back.
`default_nettype none

module stx_etx_escaped_frame_receiver (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // byte input queue side
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic [sefr_pkg::BYTE_W-1:0]          rx_byte,
    // result queue side
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic      [sefr_pkg::BYTE_W-1:0]          out_byte,
    output logic                                      msg_kind,
    output logic      [sefr_pkg::OIDX_W-1:0]          byte_index,
    output logic      [sefr_pkg::OLEN_W-1:0]          msg_length,
    output logic                                      last,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [sefr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [sefr_pkg::BYTE_W-1:0]          cfg_data
);

    logic [sefr_pkg::BYTE_W-1:0]  request_code_reg;
    logic [sefr_pkg::BYTE_W-1:0]  command_code_reg;

    // front end -> RAM write port
    logic                         ram_we;
    logic [sefr_pkg::RAM_AW-1:0]  ram_waddr;
    logic [sefr_pkg::BYTE_W-1:0]  ram_wdata;

    // back end -> RAM read port
    logic                         ram_re;
    logic [sefr_pkg::RAM_AW-1:0]  ram_raddr;
    logic [sefr_pkg::BYTE_W-1:0]  ram_rdata;

    // descriptor queue between the two halves
    logic                         desc_push;
    sefr_pkg::desc_t              desc_in;
    logic                         desc_valid;
    sefr_pkg::desc_t              desc_head;
    logic                         desc_pop;
    sefr_pkg::done_t              done;

    // config registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_code_reg <= 8'h00;
            command_code_reg <= 8'h01;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sefr_pkg::REG_REQUEST_CODE: request_code_reg <= cfg_data;
                sefr_pkg::REG_COMMAND_CODE: command_code_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: hunts, de-escapes and fills one bank while the other may drain
    sefr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .rx_byte      (rx_byte),
        .full         (full),
        .request_code (request_code_reg),
        .command_code (command_code_reg),
        .ram_we       (ram_we),
        .ram_addr     (ram_waddr),
        .ram_data     (ram_wdata),
        .desc_push    (desc_push),
        .desc         (desc_in),
        .done         (done)
    );

    // two banks of MSG_MAX bytes, bank bit on top of the address
    sefr_ram #(
        .WIDTH (sefr_pkg::BYTE_W),
        .DEPTH (sefr_pkg::RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // at most two messages outstanding, one per bank
    sefr_desc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .push_desc (desc_in),
        .pop       (desc_pop),
        .valid     (desc_valid),
        .head      (desc_head)
    );

    // back: reads the oldest message out, one beat per result
    sefr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc_head),
        .desc_pop   (desc_pop),
        .done       (done),
        .ram_re     (ram_re),
        .ram_addr   (ram_raddr),
        .ram_data   (ram_rdata),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .msg_kind   (msg_kind),
        .byte_index (byte_index),
        .msg_length (msg_length),
        .last       (last)
    );

endmodule

`default_nettype wire

>>> test/tb_stx_etx_escaped_frame_receiver.sv
// Testbench for stx_etx_escaped_frame_receiver: directed framing cases, code registers,
// receiver back-pressure and random frame traffic, all checked beat by beat.
// Depends on sefr_pkg and the RTL in rtl/.
`default_nettype none

module tb_stx_etx_escaped_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import sefr_pkg::*;

    // Stall limit: a correct run is never quiet for longer than the receiver
    // hold-off plus the drain of the messages it held back.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 500;
    localparam int DRAIN_WAIT  = 8;
    localparam int RANDOM_BYTES = 32;
    localparam int CALM_BYTES  = 28;
    localparam int IDLE_PCT    = 34;

    typedef enum logic [1:0] {MODE_HUNT, MODE_STORE, MODE_FULL} frame_mode_e;

    // one message byte as the block should hand it out
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              kind;
        logic [OIDX_W-1:0] idx;
        logic [OLEN_W-1:0] len;
        logic              fin;
    } msg_beat_t;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 msg_kind;
    logic [OIDX_W-1:0]    byte_index;
    logic [OLEN_W-1:0]    msg_length;
    logic                 last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BYTE_W-1:0]    cfg_data = '0;

    stx_etx_escaped_frame_receiver u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .rx_byte    (rx_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .msg_kind   (msg_kind),
        .byte_index (byte_index),
        .msg_length (msg_length),
        .last       (last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame predictor: its own copy of the receiver state and code regs.
    // ------------------------------------------------------------------
    frame_mode_e       pred_mode = MODE_HUNT;
    logic              pred_esc = 1'b0;
    int                pred_fill = 0;
    logic [BYTE_W-1:0] pred_store[MSG_MAX];
    logic [BYTE_W-1:0] req_code = 8'h00;
    logic [BYTE_W-1:0] cmd_code = 8'h01;

    // beats still owed by the block, oldest first
    msg_beat_t pending_beats[$];

    int  err_count = 0;
    int  rx_count = 0;       // bytes accepted so far
    bit  calm_tx = 1'b0;     // sender never idles while set
    bit  calm_rx = 1'b0;     // receiver never idles while set
    int  hold_req_cnt = 0;   // bumped by a test to ask for a receiver hold-off

    // Advance the predicted receiver by one accepted byte; a closing end byte
    // queues every stored byte of a matching message.
    function automatic void predict_rx(input logic [BYTE_W-1:0] b);
        int   n;
        logic kind;
        if (pred_mode == MODE_HUNT)
        begin
            if (b == BYTE_START)
            begin
                pred_mode = MODE_STORE;
                pred_esc  = 1'b0;
                pred_fill = 0;
            end
            return;
        end
        // end byte wins over everything else, a pending escape included
        if (b == BYTE_END)
        begin
            n = pred_fill;
            pred_mode = MODE_HUNT;
            pred_esc  = 1'b0;
            pred_fill = 0;
            if (n < 2)
                return;
            if (pred_store[1] == req_code)
                kind = KIND_REQUEST;
            else if (pred_store[1] == cmd_code)
                kind = KIND_COMMAND;
            else
                return;
            for (int i = 0; i < n; i++)
                pending_beats.push_back('{data: pred_store[i], kind: kind,
                                          idx: OIDX_W'(i), len: OLEN_W'(n),
                                          fin: (i == n - 1)});
            return;
        end
        // store full: everything up to the end byte is dropped
        if (pred_mode != MODE_STORE)
            return;
        if (pred_esc)
        begin
            pred_esc = 1'b0;
            b = b - BYTE_ESC;
        end
        else if (b == BYTE_ESC)
        begin
            pred_esc = 1'b1;
            return;
        end
        if (pred_fill < MSG_MAX)
        begin
            pred_store[pred_fill] = b;
            pred_fill++;
        end
        if (pred_fill >= MSG_MAX)
            pred_mode = MODE_FULL;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte; returns in the time step of the edge that took it.
    // push stays high so back-to-back bytes go out with no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while (!calm_tx && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (full);
        predict_rx(b);
        rx_count++;
    endtask

    // Wrap a message body in start/end bytes. Bytes that collide with the end
    // or escape byte are always escaped, a few others at random. 0xF3 cannot be
    // escaped: its escaped form is the end byte itself.
    task automatic send_frame(input byte_q_t body, input bit close);
        logic [BYTE_W-1:0] v;
        send_byte(BYTE_START);
        foreach (body[i])
        begin
            v = body[i];
            if (v == BYTE_END || v == BYTE_ESC
                || (v != 8'hF3 && $urandom_range(9) == 0))
            begin
                send_byte(BYTE_ESC);
                send_byte(v + BYTE_ESC);
            end
            else
            begin
                send_byte(v);
            end
        end
        if (close)
            send_byte(BYTE_END);
    endtask

    function automatic byte_q_t make_body(input int n, input logic [BYTE_W-1:0] type_byte);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(i == 1 ? type_byte : BYTE_W'($urandom));
        return q;
    endfunction

    // type byte: mostly one of the two codes, sometimes anything
    function automatic logic [BYTE_W-1:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return req_code;
        if (r < 85)
            return cmd_code;
        return BYTE_W'($urandom);
    endfunction

    // Drop push, wait out every owed beat, then let any dropped frame settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Code registers change only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_REQUEST_CODE)
            req_code = val;
        else
            cmd_code = val;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: check the beat taken at this edge, then pick pop.
    // Signals are read right after the edge, so they hold pre-edge values.
    // ------------------------------------------------------------------
    int        hold_seen = 0;
    int        hold_left = 0;
    msg_beat_t want_beat;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_beats.size() == 0)
            begin
                report_mismatch("unexpected beat", out_byte, 0);
            end
            else
            begin
                want_beat = pending_beats.pop_front();
                if (out_byte !== want_beat.data)
                    report_mismatch("out_byte", out_byte, want_beat.data);
                if (msg_kind !== want_beat.kind)
                    report_mismatch("msg_kind", msg_kind, want_beat.kind);
                if (byte_index !== want_beat.idx)
                    report_mismatch("byte_index", byte_index, want_beat.idx);
                if (msg_length !== want_beat.len)
                    report_mismatch("msg_length", msg_length, want_beat.len);
                if (last !== want_beat.fin)
                    report_mismatch("last", last, want_beat.fin);
            end
        end
        // hold-off requested by a test: counted here, in cycles
        if (hold_req_cnt != hold_seen)
        begin
            hold_seen = hold_req_cnt;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            pop <= calm_rx || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: ends the run after too many cycles with no beat moving.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Framing rules under reset codes (request 0x00, command 0x01).
    task automatic test_framing();
        byte_q_t body;
        // noise while hunting, end byte included: all ignored
        send_byte(BYTE_END);
        send_byte(8'hFF);
        send_byte(8'h00);
        // plain request, exactly two bytes
        send_frame('{8'hAA, 8'h00}, 1'b1);
        // command: escaped type byte, escape wrapping below zero, start byte as data
        send_byte(BYTE_START);
        send_byte(8'h7E);
        send_byte(BYTE_ESC);
        send_byte(8'h11);
        send_byte(BYTE_ESC);
        send_byte(8'h00);
        send_byte(BYTE_START);
        send_byte(8'hFF);
        send_byte(BYTE_END);
        // escape left pending when the end byte arrives
        send_byte(BYTE_START);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(BYTE_ESC);
        send_byte(BYTE_END);
        // too short: empty and one-byte frames
        send_byte(BYTE_START);
        send_byte(BYTE_END);
        send_byte(BYTE_START);
        send_byte(8'h01);
        send_byte(BYTE_END);
        // type byte matching neither code
        send_frame('{8'h00, 8'h77, 8'h12}, 1'b1);
        // overfull frame: bytes past the store size, and a trailing escape, dropped
        body = make_body(MSG_MAX + 4, 8'h01);
        send_frame(body, 1'b0);
        send_byte(BYTE_ESC);
        send_byte(BYTE_END);
        // exactly full
        send_frame(make_body(MSG_MAX, 8'h00), 1'b1);
    endtask

    // Code registers: extremes, codes equal to framing bytes, both codes equal.
    task automatic test_codes();
        write_reg(REG_REQUEST_CODE, 8'hFF);
        write_reg(REG_COMMAND_CODE, 8'h00);
        send_frame('{8'h10, 8'hFF, 8'h03}, 1'b1);
        send_frame('{8'h20, 8'h00}, 1'b1);
        send_frame('{8'h30, 8'h01}, 1'b1);
        write_reg(REG_REQUEST_CODE, BYTE_END);
        write_reg(REG_COMMAND_CODE, BYTE_ESC);
        send_frame('{8'h01, BYTE_END, 8'h55}, 1'b1);
        send_frame('{8'h02, BYTE_ESC, 8'h66, 8'h77}, 1'b1);
        // both equal: reported as request
        write_reg(REG_COMMAND_CODE, BYTE_END);
        send_frame('{8'h99, BYTE_END}, 1'b1);
        write_reg(REG_REQUEST_CODE, BYTE_START);
        write_reg(REG_COMMAND_CODE, 8'hFF);
        send_frame('{8'h00, BYTE_START, 8'hC3}, 1'b1);
        send_frame('{8'h00, 8'hFF}, 1'b1);
    endtask

    // Receiver holds off while the sender keeps going; every frame matches,
    // so both banks fill and full stalls the third frame.
    task automatic test_backpressure();
        wait_drained();
        hold_req_cnt++;
        calm_tx = 1'b1;
        for (int f = 0; f < 3; f++)
            send_frame(make_body($urandom_range(3, 6),
                                 ($urandom_range(1) == 0) ? req_code : cmd_code), 1'b1);
        calm_tx = 1'b0;
    endtask

    // Random traffic: mostly well-formed frames, some noise and broken frames,
    // with a code change part way through.
    task automatic test_random();
        int first;
        int next_cfg;
        int r;
        int n;
        logic [BYTE_W-1:0] v;
        first    = rx_count;
        next_cfg = rx_count + 16;
        while (rx_count - first < RANDOM_BYTES)
        begin
            // a stretch with no idling on either side
            calm_tx = (rx_count - first < CALM_BYTES);
            calm_rx = calm_tx;
            if (rx_count >= next_cfg)
            begin
                next_cfg = rx_count + 40;
                r = $urandom_range(3);
                v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : BYTE_W'($urandom);
                write_reg(REG_REQUEST_CODE, v);
                write_reg(REG_COMMAND_CODE, ($urandom_range(7) == 0) ? v : BYTE_W'($urandom));
            end
            r = $urandom_range(99);
            if (r < 70)
            begin
                n = ($urandom_range(11) == 0) ? $urandom_range(MSG_MAX - 2, MSG_MAX + 3)
                                              : $urandom_range(2, 8);
                send_frame(make_body(n, pick_type()), 1'b1);
            end
            else if (r < 80)
            begin
                // line noise, framing bytes likely
                repeat ($urandom_range(1, 4))
                begin
                    v = ($urandom_range(1) == 0) ? BYTE_W'($urandom_range(BYTE_START, BYTE_ESC))
                                                 : BYTE_W'($urandom);
                    send_byte(v);
                end
            end
            else if (r < 92)
            begin
                // raw content, escapes falling where they may
                send_byte(BYTE_START);
                repeat ($urandom_range(1, 6))
                begin
                    v = ($urandom_range(3) == 0) ? BYTE_ESC : BYTE_W'($urandom);
                    if (v == BYTE_END)
                        v = pick_type();
                    send_byte(v);
                end
                send_byte(BYTE_END);
            end
            else
            begin
                send_frame(make_body($urandom_range(1), pick_type()), 1'b1);
            end
        end
        calm_tx = 1'b0;
        calm_rx = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_framing();
        test_codes();
        test_backpressure();
        test_random();
        // restore reset codes and send a last pair to prove the writes took
        write_reg(REG_REQUEST_CODE, 8'h00);
        write_reg(REG_COMMAND_CODE, 8'h01);
        send_frame('{8'h5A, 8'h00, 8'hA5}, 1'b1);
        send_frame('{8'hC3, 8'h01}, 1'b1);
        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_beats.size() != 0)
            report_mismatch("beats never delivered", 0, pending_beats.size());
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
